FILE: rtl/ggdr_pkg.sv
// shared constants, types and decode functions for the grid glyph display renderer
package ggdr_pkg;

  localparam int NumCells = 15;
  localparam int GridCols = 5;
  localparam int GridRows = 3;
  localparam int CellW    = 25;
  localparam int CellH    = 21;
  localparam int GlyphDx  = 8;
  localparam int GlyphDy  = 6;

  localparam int CellIdxW = $clog2(NumCells);

  // high-nibble mark codes of a command byte
  localparam logic [3:0] MarkCodeR = 4'h4;
  localparam logic [3:0] MarkCodeG = 4'h5;
  localparam logic [3:0] MarkCodeB = 4'h8;

  // request kinds carried on tuser
  localparam logic ReqCommand = 1'b0;
  localparam logic ReqRead    = 1'b1;

  typedef enum logic [1:0] {
    MARK_BLANK = 2'd0,
    MARK_R     = 2'd1,
    MARK_G     = 2'd2,
    MARK_B     = 2'd3
  } mark_t;

  // column split into cell column and offset inside the cell
  typedef struct packed {
    logic [2:0] slot;
    logic [4:0] offs;
  } xdec_t;

  typedef struct packed {
    logic [1:0] slot;
    logic [4:0] offs;
  } ydec_t;

  function automatic xdec_t split_x(input logic [6:0] x);
    xdec_t      d;
    logic [6:0] base;
    priority if (x >= 7'(5 * CellW)) begin
      d.slot = 3'd5;
      base   = 7'(5 * CellW);
    end else if (x >= 7'(4 * CellW)) begin
      d.slot = 3'd4;
      base   = 7'(4 * CellW);
    end else if (x >= 7'(3 * CellW)) begin
      d.slot = 3'd3;
      base   = 7'(3 * CellW);
    end else if (x >= 7'(2 * CellW)) begin
      d.slot = 3'd2;
      base   = 7'(2 * CellW);
    end else if (x >= 7'(CellW)) begin
      d.slot = 3'd1;
      base   = 7'(CellW);
    end else begin
      d.slot = 3'd0;
      base   = 7'd0;
    end
    d.offs = 5'(x - base);
    return d;
  endfunction

  function automatic ydec_t split_y(input logic [5:0] y);
    ydec_t      d;
    logic [5:0] base;
    priority if (y >= 6'(3 * CellH)) begin
      d.slot = 2'd3;
      base   = 6'(3 * CellH);
    end else if (y >= 6'(2 * CellH)) begin
      d.slot = 2'd2;
      base   = 6'(2 * CellH);
    end else if (y >= 6'(CellH)) begin
      d.slot = 2'd1;
      base   = 6'(CellH);
    end else begin
      d.slot = 2'd0;
      base   = 6'd0;
    end
    d.offs = 5'(y - base);
    return d;
  endfunction

  // 4x5 font rows, msb is the leftmost glyph pixel
  function automatic logic [3:0] font_row(input mark_t mark, input logic [2:0] gy);
    logic [3:0] r;
    r = 4'h0;
    unique case (mark)
      MARK_R: begin
        unique case (gy)
          3'd0:    r = 4'hE;
          3'd1:    r = 4'h9;
          3'd2:    r = 4'hE;
          3'd3:    r = 4'hA;
          3'd4:    r = 4'h9;
          default: r = 4'h0;
        endcase
      end
      MARK_G: begin
        unique case (gy)
          3'd0:    r = 4'h7;
          3'd1:    r = 4'h8;
          3'd2:    r = 4'hB;
          3'd3:    r = 4'h9;
          3'd4:    r = 4'h7;
          default: r = 4'h0;
        endcase
      end
      MARK_B: begin
        unique case (gy)
          3'd0:    r = 4'hE;
          3'd1:    r = 4'h9;
          3'd2:    r = 4'hE;
          3'd3:    r = 4'h9;
          3'd4:    r = 4'hE;
          default: r = 4'h0;
        endcase
      end
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ggdr_pixel.sv
// renders one 8-pixel byte of the picture from the board marks
module ggdr_pixel (
  input  ggdr_pkg::mark_t marks [ggdr_pkg::NumCells],
  input  logic [2:0]      page,
  input  logic [6:0]      column,
  output logic [7:0]      pixel_byte
);

  ggdr_pkg::xdec_t xd;
  ggdr_pkg::mark_t col_marks [ggdr_pkg::GridRows];
  logic            vline;
  logic            xin;
  logic [1:0]      gx;

  assign xd    = ggdr_pkg::split_x(column);
  assign vline = (xd.offs == 5'd0);
  // glyph spans offsets 8..15 of the cell
  assign xin   = (xd.offs >= 5'(ggdr_pkg::GlyphDx)) && (xd.offs < 5'(ggdr_pkg::GlyphDx + 8));
  assign gx    = 2'((xd.offs - 5'(ggdr_pkg::GlyphDx)) >> 1);

  // marks of the cell column under this byte, one per cell row
  always_comb begin
    for (int r = 0; r < ggdr_pkg::GridRows; r++) begin
      unique case (xd.slot)
        3'd0:    col_marks[r] = marks[r * ggdr_pkg::GridCols + 0];
        3'd1:    col_marks[r] = marks[r * ggdr_pkg::GridCols + 1];
        3'd2:    col_marks[r] = marks[r * ggdr_pkg::GridCols + 2];
        3'd3:    col_marks[r] = marks[r * ggdr_pkg::GridCols + 3];
        3'd4:    col_marks[r] = marks[r * ggdr_pkg::GridCols + 4];
        default: col_marks[r] = ggdr_pkg::MARK_BLANK;
      endcase
    end
  end

  for (genvar n = 0; n < 8; n++) begin : g_bit
    ggdr_pkg::ydec_t yd;
    ggdr_pkg::mark_t mk;
    logic            yin;
    logic [2:0]      gy;
    logic [3:0]      frow;

    assign yd = ggdr_pkg::split_y({page, 3'(n)});
    assign mk = (yd.slot < 2'(ggdr_pkg::GridRows)) ? col_marks[yd.slot[1:0]]
                                                    : ggdr_pkg::MARK_BLANK;
    assign yin  = (yd.offs >= 5'(ggdr_pkg::GlyphDy)) && (yd.offs < 5'(ggdr_pkg::GlyphDy + 10));
    assign gy   = 3'((yd.offs - 5'(ggdr_pkg::GlyphDy)) >> 1);
    assign frow = ggdr_pkg::font_row(mk, gy);

    // grid lines, then the doubled glyph pixel (font bit 3-gx)
    assign pixel_byte[n] = vline || (yd.offs == 5'd0) || (xin && yin && frow[~gx]);
  end

endmodule

FILE: rtl/grid_glyph_display_renderer.sv
// top level of the grid glyph display renderer: board store and item pipeline
//
// keeps a 5x3 board of marked cells and renders bytes of a 128x64 picture
// input channel (in_*): tuser is the request kind, 0 = board command,
//   1 = read one picture byte; tdata carries command byte, page and column
// result channel (out_*): one result item per input item, in order;
//   tdata is the picture byte (zero for commands), tuser the accepted flag
// a command writes one cell: low nibble cell index, high nibble mark code
//   (4 = R, 5 = G, 8 = B); index 15 is ignored and reports not accepted
// pipeline: input register, then result register after the render/decode logic
// throughput: one item per cycle unless the receiver stalls; the whole render is a
//   single pass of constant-divisor decode, a cell lookup and a font table read
// a command updates the board as it leaves the input register, so any
//   later read sees it
// reset (rst_n low, synchronous) clears both pipeline valids and all cells
// when the receiver stalls, the result register holds, the input register
//   fills and in_tready drops only once both are occupied
module grid_glyph_display_renderer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command_byte[7:0], page[10:8], column[17:11], zero fill
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // pixel_byte[7:0]
  output logic        out_tuser   // accepted
);

  // input register
  logic       s1_valid_r;
  logic       s1_req_r;
  logic [7:0] s1_cmd_r;
  logic [2:0] s1_page_r;
  logic [6:0] s1_col_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_pixel_r;
  logic       out_acc_r;

  // board
  ggdr_pkg::mark_t marks_r   [ggdr_pkg::NumCells];
  ggdr_pkg::mark_t marks_nxt [ggdr_pkg::NumCells];

  logic                          advance;
  logic                          in_fire;
  logic [ggdr_pkg::CellIdxW-1:0] cell_idx;
  logic [3:0]                    mark_code;
  logic                          idx_ok;
  logic                          code_ok;
  ggdr_pkg::mark_t               new_mark;
  logic [7:0]                    rendered;
  logic [7:0]                    out_pixel_nxt;
  logic                          out_acc_nxt;

  // result register frees up when empty or taken this cycle
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign cell_idx  = s1_cmd_r[3:0];
  assign mark_code = s1_cmd_r[7:4];
  assign idx_ok    = (cell_idx < 4'(ggdr_pkg::NumCells));

  always_comb begin
    code_ok  = 1'b1;
    new_mark = ggdr_pkg::MARK_BLANK;
    priority if (mark_code == ggdr_pkg::MarkCodeR) begin
      new_mark = ggdr_pkg::MARK_R;
    end else if (mark_code == ggdr_pkg::MarkCodeG) begin
      new_mark = ggdr_pkg::MARK_G;
    end else if (mark_code == ggdr_pkg::MarkCodeB) begin
      new_mark = ggdr_pkg::MARK_B;
    end else begin
      code_ok = 1'b0;   // unknown code leaves the cell as it is
    end
  end

  // board write as the command leaves the input register
  always_comb begin
    for (int i = 0; i < ggdr_pkg::NumCells; i++) begin
      marks_nxt[i] = marks_r[i];
      if (s1_valid_r && advance && (s1_req_r == ggdr_pkg::ReqCommand) && idx_ok &&
          code_ok && (cell_idx == 4'(i))) begin
        marks_nxt[i] = new_mark;
      end
    end
  end

  ggdr_pixel u_pixel (
    .marks      (marks_r),
    .page       (s1_page_r),
    .column     (s1_col_r),
    .pixel_byte (rendered)
  );

  always_comb begin
    if (s1_req_r == ggdr_pkg::ReqRead) begin
      out_pixel_nxt = rendered;
      out_acc_nxt   = 1'b1;
    end else begin
      out_pixel_nxt = 8'h00;
      out_acc_nxt   = idx_ok;
    end
  end

  // control state and board
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ggdr_pkg::NumCells; i++) begin
        marks_r[i] <= ggdr_pkg::MARK_BLANK;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      for (int i = 0; i < ggdr_pkg::NumCells; i++) begin
        marks_r[i] <= marks_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= in_tuser;
      s1_cmd_r  <= in_tdata[7:0];
      s1_page_r <= in_tdata[10:8];
      s1_col_r  <= in_tdata[17:11];
    end
    if (advance && s1_valid_r) begin
      out_pixel_r <= out_pixel_nxt;
      out_acc_r   <= out_acc_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tuser  = out_acc_r;

endmodule
